### rtl/core/cksf_pkg.sv
// ----------------------------------------------------------------------------
// cksf_pkg
// Shared types, byte codes and the checksum step for the stuffing framer.
// ----------------------------------------------------------------------------
package cksf_pkg;

   localparam logic [15:0] CK_INIT   = 16'h147A;
   localparam logic [15:0] CK_INVERT = 16'hFFFF;
   localparam logic [7:0]  SPECIAL   = 8'hFE;
   localparam logic [7:0]  STUFF     = 8'hF0;
   localparam logic [7:0]  FOOT_END  = 8'h0D;

   // one accepted request, with the checksum already folded in
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        hdr;    // request opens a frame
      logic [15:0] ck;     // checksum after this byte
   } job_type;

   // rotate left by one, invert, add high byte and data byte
   function automatic logic [15:0] ck_update(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = {c[14:0], c[15]} ^ CK_INVERT;
      ck_update = r + {8'h00, r[15:8]} + {8'h00, b};
   endfunction

endpackage

### rtl/core/cksf_front.sv
// ----------------------------------------------------------------------------
// cksf_front
// Frame state and running checksum; builds the job for an accepted request.
// ----------------------------------------------------------------------------
module cksf_front
   import cksf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] data_byte,
   input  logic       frame_last,
   output job_type    job
);

   logic        in_frame_ff, in_frame_in;
   logic [15:0] check_sum_ff, check_sum_in;
   logic [15:0] ck_new;

   always_comb begin
      ck_new       = ck_update(check_sum_ff, data_byte);
      job.data     = data_byte;
      job.last     = frame_last;
      job.hdr      = ~in_frame_ff;
      job.ck       = ck_new;
      in_frame_in  = in_frame_ff;
      check_sum_in = check_sum_ff;
      if (take) begin
         in_frame_in  = ~frame_last;
         check_sum_in = frame_last ? CK_INIT : ck_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         check_sum_ff <= CK_INIT;
      end else begin
         in_frame_ff  <= in_frame_in;
         check_sum_ff <= check_sum_in;
      end
   end

endmodule

### rtl/core/cksf_emit.sv
// ----------------------------------------------------------------------------
// cksf_emit
// Holds one job and walks its output slots, one byte per cycle unless the
// response register is stalled, into the response register.
// ----------------------------------------------------------------------------
module cksf_emit
   import cksf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  job_type    job_in,
   output logic       job_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_end
);

   typedef enum logic [3:0] {
      S_HDR0, S_HDR1, S_DATA, S_DSTF, S_CKH, S_CKHS, S_CKL, S_CKLS, S_FT0, S_FT1
   } slot_type;

   slot_type    slot_ff, slot_in, slot_start;
   job_type     job_ff;
   logic        job_valid_ff;
   logic        rsp_valid_ff, rsp_run_last_ff, rsp_frame_end_ff;
   logic [7:0]  rsp_byte_ff;
   logic        advance, fin;
   logic [7:0]  byte_cur;

   assign advance    = ~rsp_valid_ff | rsp_ready;
   assign job_ready  = ~job_valid_ff | (advance & fin);
   assign slot_start = job_in.hdr ? S_HDR0 : S_DATA;

   always_comb begin
      slot_in  = slot_ff;
      fin      = 1'b0;
      byte_cur = SPECIAL;
      unique case (slot_ff)
         S_HDR0: begin
            slot_in = S_HDR1;
         end
         S_HDR1: begin
            slot_in = S_DATA;
         end
         S_DATA: begin
            byte_cur = job_ff.data;
            if (job_ff.data == SPECIAL) slot_in = S_DSTF;
            else if (job_ff.last)      slot_in = S_CKH;
            else                       fin = 1'b1;
         end
         S_DSTF: begin
            byte_cur = STUFF;
            if (job_ff.last) slot_in = S_CKH;
            else             fin = 1'b1;
         end
         S_CKH: begin
            byte_cur = job_ff.ck[15:8];
            slot_in  = (job_ff.ck[15:8] == SPECIAL) ? S_CKHS : S_CKL;
         end
         S_CKHS: begin
            byte_cur = STUFF;
            slot_in  = S_CKL;
         end
         S_CKL: begin
            byte_cur = job_ff.ck[7:0];
            slot_in  = (job_ff.ck[7:0] == SPECIAL) ? S_CKLS : S_FT0;
         end
         S_CKLS: begin
            byte_cur = STUFF;
            slot_in  = S_FT0;
         end
         S_FT0: begin
            slot_in = S_FT1;
         end
         S_FT1: begin
            byte_cur = FOOT_END;
            fin      = 1'b1;
         end
         default: begin
            fin = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= S_HDR0;
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            rsp_valid_ff     <= job_valid_ff;
            rsp_byte_ff      <= byte_cur;
            rsp_run_last_ff  <= fin;
            rsp_frame_end_ff <= (slot_ff == S_FT1);
         end
         if (load) begin
            job_ff       <= job_in;
            job_valid_ff <= 1'b1;
            slot_ff      <= slot_start;
         end else if (advance && job_valid_ff) begin
            if (fin) job_valid_ff <= 1'b0;
            else     slot_ff <= slot_in;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_run_last  = rsp_run_last_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule

### rtl/core/checksum_stuffing_framer.sv
// ----------------------------------------------------------------------------
// checksum_stuffing_framer
// Byte-stuffed framer with a 16-bit checksum, header FE FE and footer FE 0D.
// ----------------------------------------------------------------------------
// The framer sends one output byte per cycle while rsp_ready is high. Each
// request causes one output byte for a plain middle byte and up to 10 for a
// one-byte frame with stuffing on the data and both checksum bytes. The output
// slot sequencer is the limit: it holds one request and accepts the next one
// in the cycle its final byte enters the response register, so a stream of
// plain middle bytes flows at one request per cycle while rsp_ready is high.
// A request's first byte passes the job register, then the response register.
module checksum_stuffing_framer
   import cksf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_frame_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_end
);

   job_type job;
   logic    take;
   logic    job_ready;

   assign req_ready = job_ready;
   assign take      = req_valid & job_ready;

   cksf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .data_byte  (req_data_byte),
      .frame_last (req_frame_last),
      .job        (job)
   );

   cksf_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load          (take),
      .job_in        (job),
      .job_ready     (job_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

### rtl/core/cksf_checker.sv
// ----------------------------------------------------------------------------
// cksf_checker
// Port-level checks on the framer's response stream.
// ----------------------------------------------------------------------------
module cksf_checker
   import cksf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_frame_end
);

   // a frame always ends on the footer code
   a_end_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_out_byte == FOOT_END)
      else $error("frame end without footer code");

   // footer is the final byte of its request
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_last)
      else $error("frame end not marked as run end");

   // footer is always preceded directly by an unstuffed FE
   a_end_after_fe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end && !$past(rsp_frame_end) |->
      $past(rsp_valid) && $past(rsp_out_byte) == SPECIAL)
      else $error("footer ordering broken");

   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
      && $stable(rsp_run_last) && $stable(rsp_frame_end))
      else $error("response changed while stalled");

   // a waiting request is not withdrawn
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request dropped before acceptance");

endmodule

bind checksum_stuffing_framer cksf_checker u_cksf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_run_last  (rsp_run_last),
   .rsp_frame_end (rsp_frame_end)
);
